### hdl/tswd_pkg.sv
// Shared types, widths and reset values for the touch stroke wiggle detector.
// No dependencies; every other file imports this package.
`default_nettype none

package tswd_pkg;

    // Panel coordinate width
    localparam int COORD_BITS  = 10;

    // Register and field widths
    localparam int CFG_COORD_W = 10;
    localparam int TIMEOUT_W   = 16;
    localparam int REV_W       = 3;
    localparam int TIME_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Compare widths covering both coordinates and register values
    localparam int UCMP_W = (COORD_BITS > CFG_COORD_W) ? COORD_BITS : CFG_COORD_W;
    localparam int SCMP_W = UCMP_W + 2;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef enum logic [1:0] {
        HEAD_NONE  = 2'd0,
        HEAD_RIGHT = 2'd1,
        HEAD_LEFT  = 2'd2
    } heading_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BAND_TOP      = 3'd0,
        REG_BAND_BOTTOM   = 3'd1,
        REG_MIN_LEG_DIST  = 3'd2,
        REG_MAX_DRIFT     = 3'd3,
        REG_TIMEOUT_MS    = 3'd4,
        REG_REVERSALS     = 3'd5
    } reg_idx_t;

    localparam logic [CFG_COORD_W-1:0] RST_BAND_TOP     = 10'd32;
    localparam logic [CFG_COORD_W-1:0] RST_BAND_BOTTOM  = 10'd104;
    localparam logic [CFG_COORD_W-1:0] RST_MIN_LEG_DIST = 10'd40;
    localparam logic [CFG_COORD_W-1:0] RST_MAX_DRIFT    = 10'd24;
    localparam logic [TIMEOUT_W-1:0]   RST_TIMEOUT_MS   = 16'd2000;
    localparam logic [REV_W-1:0]       RST_REVERSALS    = 3'd3;

    typedef struct packed {
        logic [CFG_COORD_W-1:0] band_top;
        logic [CFG_COORD_W-1:0] band_bottom;
        logic [CFG_COORD_W-1:0] min_leg_distance;
        logic [CFG_COORD_W-1:0] max_vertical_drift;
        logic [TIMEOUT_W-1:0]   timeout_ms;
        logic [REV_W-1:0]       reversals_needed;
    } cfg_t;

    typedef struct packed {
        logic              touched;
        coord_t            pos_x;
        coord_t            pos_y;
        logic [TIME_W-1:0] time_ms;
    } sample_t;

    typedef struct packed {
        logic gesture_seen;
        logic tracking;
    } core_status_t;

endpackage

`default_nettype wire

### hdl/tswd_sample_if.sv
// Touch sample channel: valid/ready plus one sample item.
// Depends on tswd_pkg.
`default_nettype none

interface tswd_sample_if import tswd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              touched;
    coord_t            pos_x;
    coord_t            pos_y;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, output touched, output pos_x, output pos_y,
                    output time_ms, input ready);
    modport sink   (input valid, input touched, input pos_x, input pos_y,
                    input time_ms, output ready);
endinterface

`default_nettype wire

### hdl/tswd_result_if.sv
// Result channel: valid/ready plus the gesture flag of one item.
// Depends on tswd_pkg.
`default_nettype none

interface tswd_result_if import tswd_pkg::*; ();
    logic valid;
    logic ready;
    logic gesture_seen;

    modport source (output valid, output gesture_seen, input ready);
    modport sink   (input valid, input gesture_seen, output ready);
endinterface

`default_nettype wire

### hdl/tswd_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on tswd_pkg.
`default_nettype none

interface tswd_cfg_if import tswd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/tswd_cfg_regs.sv
// Configuration register file, written through the cfg channel.
// Depends on tswd_pkg and tswd_cfg_if.
`default_nettype none

module tswd_cfg_regs import tswd_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tswd_cfg_if.sink   cfg,
    output cfg_t       regs
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_BAND_TOP:     cfg_next.band_top           = cfg.data[CFG_COORD_W-1:0];
                REG_BAND_BOTTOM:  cfg_next.band_bottom        = cfg.data[CFG_COORD_W-1:0];
                REG_MIN_LEG_DIST: cfg_next.min_leg_distance   = cfg.data[CFG_COORD_W-1:0];
                REG_MAX_DRIFT:    cfg_next.max_vertical_drift = cfg.data[CFG_COORD_W-1:0];
                REG_TIMEOUT_MS:   cfg_next.timeout_ms         = cfg.data[TIMEOUT_W-1:0];
                REG_REVERSALS:    cfg_next.reversals_needed   = cfg.data[REV_W-1:0];
                default:          ;  // unmapped index: write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_top           <= RST_BAND_TOP;
            cfg_reg.band_bottom        <= RST_BAND_BOTTOM;
            cfg_reg.min_leg_distance   <= RST_MIN_LEG_DIST;
            cfg_reg.max_vertical_drift <= RST_MAX_DRIFT;
            cfg_reg.timeout_ms         <= RST_TIMEOUT_MS;
            cfg_reg.reversals_needed   <= RST_REVERSALS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### hdl/tswd_core.sv
// Gesture state and its update logic for one registered sample.
// Depends on tswd_pkg.
`default_nettype none

module tswd_core import tswd_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire sample_t sample,
    input  wire logic    fire,
    output core_status_t status
);

    logic              tracking_reg,       tracking_next;
    coord_t            anchor_y_reg,       anchor_y_next;
    coord_t            leg_origin_x_reg,   leg_origin_x_next;
    heading_t          heading_reg,        heading_next;
    logic [REV_W-1:0]  reversal_count_reg, reversal_count_next;
    logic [TIME_W-1:0] start_time_reg,     start_time_next;

    logic [UCMP_W-1:0]        y_u;
    logic [UCMP_W-1:0]        dy_u;
    coord_t                   dy_abs;
    logic                     in_band;
    logic [TIME_W-1:0]        elapsed;
    logic                     abort;
    logic signed [SCMP_W-1:0] dx;
    logic signed [SCMP_W-1:0] leg_dist;
    logic signed [SCMP_W-1:0] neg_dist;
    logic                     go_right;
    logic                     go_left;
    heading_t                 dir;
    logic [REV_W-1:0]         cnt_inc;
    logic                     gesture;

    // Band, drift and timeout checks
    assign y_u     = UCMP_W'(sample.pos_y);
    assign in_band = (y_u >= UCMP_W'(cfg.band_top)) && (y_u <= UCMP_W'(cfg.band_bottom));
    assign dy_abs  = (sample.pos_y >= anchor_y_reg) ? (sample.pos_y - anchor_y_reg)
                                                    : (anchor_y_reg - sample.pos_y);
    assign dy_u    = UCMP_W'(dy_abs);
    assign elapsed = sample.time_ms - start_time_reg;   // wraps mod 2^32
    assign abort   = !in_band || (elapsed > TIME_W'(cfg.timeout_ms))
                     || (dy_u > UCMP_W'(cfg.max_vertical_drift));

    // Horizontal leg classification
    assign dx       = SCMP_W'(sample.pos_x) - SCMP_W'(leg_origin_x_reg);
    assign leg_dist = SCMP_W'(cfg.min_leg_distance);
    assign neg_dist = -leg_dist;
    assign go_right = (dx >= leg_dist);
    assign go_left  = !go_right && (dx <= neg_dist);
    assign dir      = go_right ? HEAD_RIGHT : HEAD_LEFT;
    assign cnt_inc  = reversal_count_reg + REV_W'(1);

    always_comb
    begin
        tracking_next       = tracking_reg;
        anchor_y_next       = anchor_y_reg;
        leg_origin_x_next   = leg_origin_x_reg;
        heading_next        = heading_reg;
        reversal_count_next = reversal_count_reg;
        start_time_next     = start_time_reg;
        gesture             = 1'b0;

        if (fire)
        begin
            if (!sample.touched || (!tracking_reg && !in_band) || (tracking_reg && abort))
            begin
                tracking_next       = 1'b0;
                anchor_y_next       = '0;
                leg_origin_x_next   = '0;
                heading_next        = HEAD_NONE;
                reversal_count_next = '0;
                start_time_next     = '0;
            end
            else if (!tracking_reg)
            begin
                tracking_next       = 1'b1;
                anchor_y_next       = sample.pos_y;
                leg_origin_x_next   = sample.pos_x;
                heading_next        = HEAD_NONE;
                reversal_count_next = '0;
                start_time_next     = sample.time_ms;
            end
            else if (go_right || go_left)
            begin
                heading_next      = dir;
                leg_origin_x_next = sample.pos_x;
                if ((heading_reg != HEAD_NONE) && (dir != heading_reg))
                begin
                    reversal_count_next = cnt_inc;
                    if (cnt_inc >= cfg.reversals_needed)
                    begin
                        gesture             = 1'b1;
                        tracking_next       = 1'b0;
                        anchor_y_next       = '0;
                        leg_origin_x_next   = '0;
                        heading_next        = HEAD_NONE;
                        reversal_count_next = '0;
                        start_time_next     = '0;
                    end
                end
            end
        end
    end

    assign status.gesture_seen = gesture;
    assign status.tracking     = tracking_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg       <= 1'b0;
            anchor_y_reg       <= '0;
            leg_origin_x_reg   <= '0;
            heading_reg        <= HEAD_NONE;
            reversal_count_reg <= '0;
            start_time_reg     <= '0;
        end
        else
        begin
            tracking_reg       <= tracking_next;
            anchor_y_reg       <= anchor_y_next;
            leg_origin_x_reg   <= leg_origin_x_next;
            heading_reg        <= heading_next;
            reversal_count_reg <= reversal_count_next;
            start_time_reg     <= start_time_next;
        end
    end

endmodule

`default_nettype wire

### hdl/touch_stroke_wiggle_detector.sv
// Touch stroke wiggle detector: top level with input and result registers.
// Depends on tswd_pkg, tswd_sample_if, tswd_result_if, tswd_cfg_if,
// tswd_cfg_regs and tswd_core.
//
// Usage:
//  - samples: one touch sample per item (touched, pos_x, pos_y, time_ms).
//  - results: exactly one item per sample; gesture_seen is 1 on the sample
//    that completes a back-and-forth stroke inside the band.
//  - cfg: register writes (index 0..5), always ready; unmapped indexes are
//    dropped. Write only while no sample is in flight.
// Data path (two-stage): an accepted sample waits in the input register until
//  the result register can take a value and is then evaluated against the
//  gesture state: input register -> update logic -> result register.
// Throughput: one item per cycle while results.ready stays high; the gesture
//  state registers feed back through the core's compare/update logic.
// Stalls: while results.ready is low and the result register is full, a
//  buffered sample stays and samples.ready drops; no item is lost.
// Reset: rst_n (async, active low) empties both registers, clears the gesture
//  state and loads the register defaults.
`default_nettype none

module touch_stroke_wiggle_detector import tswd_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tswd_sample_if.sink  samples,
    tswd_result_if.source results,
    tswd_cfg_if.sink     cfg
);

    cfg_t         cfg_regs;
    core_status_t core_status;

    // Input stage
    logic    in_valid_reg, in_valid_next;
    sample_t in_sample_reg, in_sample_next;

    // Result stage
    logic    res_valid_reg, res_valid_next;
    logic    res_seen_reg,  res_seen_next;

    logic    advance;   // result register can take a new value
    logic    fire;      // registered sample is evaluated this cycle
    logic    take;      // new sample accepted this cycle

    assign advance       = !res_valid_reg || results.ready;
    assign fire          = in_valid_reg && advance;
    assign samples.ready = !in_valid_reg || advance;
    assign take          = samples.valid && samples.ready;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_sample_next = in_sample_reg;
        if (take)
        begin
            in_valid_next          = 1'b1;
            in_sample_next.touched = samples.touched;
            in_sample_next.pos_x   = samples.pos_x;
            in_sample_next.pos_y   = samples.pos_y;
            in_sample_next.time_ms = samples.time_ms;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_seen_next  = res_seen_reg;
        if (fire)
        begin
            res_valid_next = 1'b1;
            res_seen_next  = core_status.gesture_seen;
        end
        else if (results.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        in_sample_reg <= in_sample_next;
        res_seen_reg  <= res_seen_next;
    end

    assign results.valid        = res_valid_reg;
    assign results.gesture_seen = res_seen_reg;

    tswd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    tswd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_regs),
        .sample (in_sample_reg),
        .fire   (fire),
        .status (core_status)
    );

    // Every evaluated sample lands in the result register
    a_fire_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("evaluated sample produced no result");

    // A buffered sample stays until evaluated
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("buffered sample dropped during stall");

    // A reported gesture clears tracking
    a_gesture_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && core_status.gesture_seen |=> !core_status.tracking)
        else $error("tracking still set after gesture report");

    // A release always ends tracking
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !in_sample_reg.touched |=> !core_status.tracking)
        else $error("tracking still set after release");

endmodule

`default_nettype wire
